// ===== design/rob_pkg.sv =====
// ----------------------------------------------------------------------------
// rob_pkg
// shared types and constants of the sequence-number reorder buffer
// ----------------------------------------------------------------------------
`default_nettype none

package rob_pkg;

   // geometry
   localparam int NUM_ROOMS     = 10;
   localparam int MAX_SERVERS   = 8;
   localparam int WINDOW        = 16;   // power of two, slot = index mod window
   localparam int PAYLOAD_WIDTH = 32;
   localparam int MAX_OUT       = 16;   // releases per request

   localparam int NUM_PAIRS  = MAX_SERVERS * NUM_ROOMS;
   localparam int NUM_SLOTS  = NUM_PAIRS * WINDOW;
   localparam int PAIR_BITS  = $clog2(NUM_PAIRS);
   localparam int WIN_BITS   = $clog2(WINDOW);
   localparam int SLOT_BITS  = PAIR_BITS + WIN_BITS;
   localparam int NOUT_BITS  = $clog2(MAX_OUT + 1);

   // field widths
   localparam int SENDER_W  = 4;
   localparam int ROOM_W    = 4;
   localparam int SEQ_W     = 32;
   localparam int HANDLE_W  = 32;
   localparam int STATUS_W  = 3;

   // register file
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_ORDERING_MODE = 1'b0;
   localparam logic REG_SERVER_COUNT  = 1'b1;
   localparam logic [3:0] SERVER_COUNT_RESET = 4'd8;

   typedef enum logic [STATUS_W-1:0] {
      ST_DELIVERED  = 3'd0,
      ST_HELD       = 3'd1,
      ST_BAD_ROOM   = 3'd2,
      ST_BAD_SENDER = 3'd3,
      ST_BAD_INDEX  = 3'd4,
      ST_STALE      = 3'd5,
      ST_BEYOND     = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CHECK,
      S_RELEASE,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic                ordering_mode;
      logic [SENDER_W-1:0] server_limit;
   } cfg_type;

   typedef struct packed {
      logic [SEQ_W-1:0]  cnt;
      logic [WINDOW-1:0] held;
   } pair_word_type;

endpackage

`default_nettype wire

// ===== design/rob_req_if.sv =====
// ----------------------------------------------------------------------------
// rob_req_if
// request channel: one message from a peer server
// ----------------------------------------------------------------------------
`default_nettype none

interface rob_req_if import rob_pkg::*;;
   logic                valid;
   logic                ready;
   logic [SENDER_W-1:0] sender_index;
   logic [ROOM_W-1:0]   room_number;
   logic [SEQ_W-1:0]    sequence_index;
   logic [HANDLE_W-1:0] payload_handle;

   modport source (output valid, sender_index, room_number, sequence_index,
                   payload_handle, input ready);
   modport sink   (input valid, sender_index, room_number, sequence_index,
                   payload_handle, output ready);
endinterface

`default_nettype wire

// ===== design/rob_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rob_rsp_if
// result channel: delivered or flagged message
// ----------------------------------------------------------------------------
`default_nettype none

interface rob_rsp_if import rob_pkg::*;;
   logic                valid;
   logic                ready;
   logic [ROOM_W-1:0]   out_room;
   logic [HANDLE_W-1:0] out_payload;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, out_room, out_payload, status, last, input ready);
   modport sink   (input valid, out_room, out_payload, status, last, output ready);
endinterface

`default_nettype wire

// ===== design/rob_csr.sv =====
// ----------------------------------------------------------------------------
// rob_csr
// apb register file: ordering mode and server count
// ----------------------------------------------------------------------------
`default_nettype none

module rob_csr import rob_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic                mode_ff, mode_in;
   logic [SENDER_W-1:0] count_ff, count_in;
   logic                wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_ORDERING_MODE: mode_in  = pwdata[0];
            REG_SERVER_COUNT:  count_in = pwdata[SENDER_W-1:0];
            default:           mode_in  = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         count_ff <= SERVER_COUNT_RESET;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_ORDERING_MODE: prdata = {{(CSR_DATA_W-1){1'b0}}, mode_ff};
         REG_SERVER_COUNT:  prdata = {{(CSR_DATA_W-SENDER_W){1'b0}}, count_ff};
         default:           prdata = '0;
      endcase
   end

   // counts above the supported peers act as the maximum
   assign cfg.ordering_mode = mode_ff;
   assign cfg.server_limit  = (count_ff > SENDER_W'(MAX_SERVERS)) ?
                              SENDER_W'(MAX_SERVERS) : count_ff;

endmodule

`default_nettype wire

// ===== design/fifo_order_reorder_buffer_top.sv =====
// ----------------------------------------------------------------------------
// fifo_order_reorder_buffer_top
// per-sender, per-room in-order delivery with a holdback window
// ----------------------------------------------------------------------------
//  channel   direction  handshake            content
//  req_ch    in         valid/ready          sender, room, sequence, handle
//  rsp_ch    out        valid/ready          room, payload, status, last
//  apb       in/out     psel/penable/pready  ordering mode, server count
//
//  a request is taken only in idle; the next one waits until this one's last
//  result sits in the output register
//  flagged or unordered requests pass through pair lookup and check
//  an in-order request that is only held passes lookup, check and release; one
//  that releases n messages then passes release and emit for each message, as
//  the pair memory and the holdback memory are read through a register
//  rsp_ch stalls hold the sequencer in place; nothing is lost or repeated
//  reset is synchronous; no clearing pass: pair rows carry valid flags
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_order_reorder_buffer_top import rob_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   rob_req_if.sink               req_ch,
   rob_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;

   rob_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer state
   state_type state_ff, state_in;

   // captured request
   logic [SENDER_W-1:0]      sender_ff;
   logic [ROOM_W-1:0]        room_ff;
   logic [SEQ_W-1:0]         seq_ff;
   logic [PAYLOAD_WIDTH-1:0] payload_ff;
   logic [PAIR_BITS-1:0]     pair_ff;

   // working copy of the pair row
   logic [SEQ_W-1:0]     cnt_ff, cnt_in;
   logic [WINDOW-1:0]    row_ff, row_in;
   logic [NOUT_BITS-1:0] n_ff, n_in;

   // pair memory: delivered count and held bits per (sender, room)
   pair_word_type        pair_mem [NUM_PAIRS];
   logic [NUM_PAIRS-1:0] pair_vld_ff;
   pair_word_type        pair_rd_ff;
   logic                 pair_rd_vld_ff;
   logic                 pair_rd_en, pair_wr_en;

   // holdback memory: payload per slot
   logic [PAYLOAD_WIDTH-1:0] hold_mem [NUM_SLOTS];
   logic [PAYLOAD_WIDTH-1:0] hold_rd_ff;
   logic                     hold_rd_en, hold_wr_en;
   logic [SLOT_BITS-1:0]     hold_wr_addr, hold_rd_addr;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ROOM_W-1:0]   rsp_room_ff;
   logic [HANDLE_W-1:0] rsp_payload_ff;
   status_type          rsp_status_ff;
   logic                rsp_last_ff;
   logic                out_free;
   logic                load;
   status_type          ld_status;
   logic [HANDLE_W-1:0] ld_payload;
   logic                ld_last;

   // lookup address of the incoming request
   logic [7:0]           acc_pair_wide;
   logic [PAIR_BITS-1:0] acc_pair;
   logic                 acc_good;

   // check of the captured request
   logic              room_bad, sender_bad, seq_zero, stale, beyond;
   logic [SEQ_W-1:0]  rd_cnt, gap;
   logic [WINDOW-1:0] rd_row, set_bit;
   logic              chk_single;
   status_type        chk_status;
   logic [HANDLE_W-1:0] chk_payload;

   // release step
   logic [SEQ_W-1:0]    cnt_next;
   logic [WIN_BITS-1:0] rel_idx;
   logic                can_rel;

   // ---------------------------------------------------------------- lookup
   assign acc_pair_wide = 8'((({4'd0, req_ch.sender_index} - 8'd1) * 8'(NUM_ROOMS))
                             + ({4'd0, req_ch.room_number} - 8'd1));
   assign acc_pair      = acc_pair_wide[PAIR_BITS-1:0];
   // only an in-order request with a valid room and sender touches the pair memory
   assign acc_good = cfg.ordering_mode
                     && (req_ch.room_number != '0)
                     && (req_ch.room_number <= ROOM_W'(NUM_ROOMS))
                     && (req_ch.sender_index != '0)
                     && (req_ch.sender_index <= cfg.server_limit);

   // ----------------------------------------------------------------- check
   assign room_bad   = (room_ff == '0) || (room_ff > ROOM_W'(NUM_ROOMS));
   assign sender_bad = (sender_ff == '0) || (sender_ff > cfg.server_limit);
   assign seq_zero   = (seq_ff == '0);
   // rows never written read as the reset value
   assign rd_cnt     = pair_rd_vld_ff ? pair_rd_ff.cnt  : '0;
   assign rd_row     = pair_rd_vld_ff ? pair_rd_ff.held : '0;
   assign stale      = (seq_ff <= rd_cnt);
   assign gap        = seq_ff - rd_cnt - SEQ_W'(1);
   assign beyond     = (gap >= SEQ_W'(WINDOW));
   assign set_bit    = WINDOW'(1) << seq_ff[WIN_BITS-1:0];

   always_comb begin
      chk_single  = 1'b1;
      chk_payload = '0;
      chk_status  = ST_HELD;
      if (room_bad) begin
         chk_status = ST_BAD_ROOM;
      end else if (sender_bad) begin
         chk_status = ST_BAD_SENDER;
      end else if (!cfg.ordering_mode) begin
         chk_status  = ST_DELIVERED;
         chk_payload = HANDLE_W'(payload_ff);
      end else if (seq_zero) begin
         chk_status = ST_BAD_INDEX;
      end else if (stale) begin
         chk_status = ST_STALE;
      end else if (beyond) begin
         chk_status = ST_BEYOND;
      end else begin
         chk_single = 1'b0;
      end
   end

   // --------------------------------------------------------------- release
   // next expected slot, counter saturates at all ones
   assign cnt_next = cnt_ff + SEQ_W'(1);
   assign rel_idx  = cnt_next[WIN_BITS-1:0];
   assign can_rel  = row_ff[rel_idx] && (n_ff < NOUT_BITS'(MAX_OUT)) && (cnt_ff != '1);

   assign hold_wr_addr = {pair_ff, seq_ff[WIN_BITS-1:0]};
   assign hold_rd_addr = {pair_ff, rel_idx};

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // -------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      req_ch.ready = (state_ff == S_IDLE) && !reset;
      pair_rd_en   = 1'b0;
      pair_wr_en   = 1'b0;
      hold_rd_en   = 1'b0;
      hold_wr_en   = 1'b0;
      load         = 1'b0;
      ld_status    = ST_DELIVERED;
      ld_payload   = '0;
      ld_last      = 1'b1;
      cnt_in       = cnt_ff;
      row_in       = row_ff;
      n_in         = n_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               pair_rd_en = acc_good;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (chk_single) begin
               // one flagged or pass-through result
               if (out_free) begin
                  load       = 1'b1;
                  ld_status  = chk_status;
                  ld_payload = chk_payload;
                  state_in   = S_IDLE;
               end
            end else begin
               // store in the window, then walk the consecutive run
               hold_wr_en = 1'b1;
               cnt_in     = rd_cnt;
               row_in     = rd_row | set_bit;
               n_in       = '0;
               state_in   = S_RELEASE;
            end
         end
         S_RELEASE: begin
            if (can_rel) begin
               hold_rd_en = 1'b1;
               row_in     = row_ff & ~(WINDOW'(1) << rel_idx);
               cnt_in     = cnt_next;
               n_in       = n_ff + NOUT_BITS'(1);
               state_in   = S_EMIT;
            end else if (out_free) begin
               // nothing consecutive: report held and write the row back
               load       = 1'b1;
               ld_status  = ST_HELD;
               pair_wr_en = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               // last when the following slot cannot be released
               load       = 1'b1;
               ld_status  = ST_DELIVERED;
               ld_payload = HANDLE_W'(hold_rd_ff);
               ld_last    = !can_rel;
               if (can_rel) begin
                  state_in = S_RELEASE;
               end else begin
                  pair_wr_en = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // capture of the accepted request
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         sender_ff  <= req_ch.sender_index;
         room_ff    <= req_ch.room_number;
         seq_ff     <= req_ch.sequence_index;
         payload_ff <= req_ch.payload_handle[PAYLOAD_WIDTH-1:0];
         pair_ff    <= acc_pair;
      end
      cnt_ff <= cnt_in;
      row_ff <= row_in;
      n_ff   <= n_in;
   end

   // ------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (pair_wr_en) begin
         pair_mem[pair_ff] <= '{cnt: cnt_ff, held: row_ff};
      end
      if (pair_rd_en) begin
         pair_rd_ff     <= pair_mem[acc_pair];
         pair_rd_vld_ff <= pair_vld_ff[acc_pair];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_vld_ff <= '0;
      end else if (pair_wr_en) begin
         pair_vld_ff[pair_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (hold_wr_en) begin
         hold_mem[hold_wr_addr] <= payload_ff;
      end
      if (hold_rd_en) begin
         hold_rd_ff <= hold_mem[hold_rd_addr];
      end
   end

   // -------------------------------------------------------- output register
   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_room_ff    <= room_ff;
         rsp_payload_ff <= ld_payload;
         rsp_status_ff  <= ld_status;
         rsp_last_ff    <= ld_last;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_room    = rsp_room_ff;
   assign rsp_ch.out_payload = rsp_payload_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.last        = rsp_last_ff;

endmodule

`default_nettype wire
